FILE: rtl/sfdl_pkg.sv
// Shared types and constants for the stereo fractional delay line.
package sfdl_pkg;

    localparam int ACTION_BITS = 2;
    localparam int DELAY_BITS  = 29;
    localparam int FRAC_BITS   = 16;
    localparam int INT_BITS    = 12;

    // Item action codes.
    localparam logic [ACTION_BITS-1:0] ACT_WRITE     = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_READ_LIN  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_READ_HERM = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_COEF,
        ST_HORNER,
        ST_LIN,
        ST_DONE
    } t_state;

endpackage

FILE: rtl/stereo_fractional_delay_line.sv
// Stereo fractional delay line with linear or cubic Hermite interpolated reads.
//
// The block holds a left and a right sample ring of DEPTH entries each (DEPTH a power
// of two) in two single-port-write, single-port-read synchronous memories, plus a write
// pointer. A write beat stores one stereo pair and advances the pointer; it produces no
// output beat. A read beat picks a channel and a signed 12.16 delay (negative delays
// clamp to zero, integer delays wrap modulo DEPTH) and returns one saturated sample.
// Because both memories have a single registered read port, the neighbours are fetched
// one per cycle: a linear read fetches two samples, and a Hermite read fetches four
// samples, forms the doubled polynomial coefficients, then runs three Horner steps on
// one shared multiplier. The input side stalls while a read is in progress. A finished
// result sits in an output register, so the next beat is already accepted while a
// result waits to be taken; a read that completes while the previous result is still
// stalled waits in its final state. After reset, a clearing pass writes zero to every
// entry of both rings, one entry per cycle, and the input side stalls until the pass
// is done.
module stereo_fractional_delay_line #(
    parameter int DEPTH       = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input channel.
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [sfdl_pkg::ACTION_BITS-1:0]     i_action,
    input  logic signed [SAMPLE_BITS-1:0]        i_left_in,
    input  logic signed [SAMPLE_BITS-1:0]        i_right_in,
    input  logic                                 i_channel_sel,
    input  logic signed [sfdl_pkg::DELAY_BITS-1:0] i_delay_amount,
    // Output channel.
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]        o_read_sample
);
    import sfdl_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int SB   = SAMPLE_BITS;
    // The Horner accumulator stays below 12 * 2^SB in magnitude, so five guard bits
    // above the sample width are enough.
    localparam int EXT  = 5;
    localparam int ACCW = SB + EXT;
    // Hermite product: accumulator times an 18-bit signed view of t.
    localparam int HPW  = ACCW + FRAC_BITS + 2;
    // Linear product: (SB+1)-bit difference times a 17-bit signed view of f.
    localparam int LPW  = SB + FRAC_BITS + 2;

    localparam logic signed [HPW-1:0] H_HALF = {{(HPW-FRAC_BITS){1'b0}}, 1'b1,
                                                {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [LPW-1:0] L_HALF = {{(LPW-FRAC_BITS){1'b0}}, 1'b1,
                                                {(FRAC_BITS-1){1'b0}}};
    localparam logic signed [ACCW-1:0] SAT_MAX = {{(EXT+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [ACCW-1:0] SAT_MIN = {{(EXT+1){1'b1}}, {(SB-1){1'b0}}};
    localparam logic signed [ACCW-1:0] ACC_ONE = {{(ACCW-1){1'b0}}, 1'b1};

    // Sample rings.
    logic [SB-1:0] r_mem_left  [DEPTH];
    logic [SB-1:0] r_mem_right [DEPTH];
    logic [SB-1:0] r_rd_left;
    logic [SB-1:0] r_rd_right;

    // Control state.
    t_state          r_state, n_state;
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_clr;
    logic            r_out_valid;

    // Per-read context captured at accept.
    logic [AW-1:0]        r_base;
    logic [FRAC_BITS-1:0] r_frac;
    logic                 r_chan;
    logic                 r_herm;

    // Fetched samples, coefficients and the accumulator.
    logic signed [SB-1:0]   r_y0, r_y1, r_y2;
    logic signed [ACCW-1:0] r_k2, r_k1, r_k0;
    logic signed [ACCW-1:0] r_acc;
    logic [1:0]             r_step;
    logic signed [SB-1:0]   r_out_data;

    // Combinational control.
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic            in_accept;
    logic            out_free;
    logic            out_load;

    // Delay decode.
    logic            dly_neg;
    logic [AW-1:0]   dly_int;
    logic [FRAC_BITS-1:0] dly_frac;

    // Datapath.
    logic signed [SB-1:0]   rdata;
    logic signed [ACCW-1:0] y0_e, y1_e, y2_e, y3_e, d12;
    logic signed [ACCW-1:0] k3, k2, k1, k0;
    logic [FRAC_BITS:0]     t_val;
    logic signed [ACCW-1:0] k_sel;
    logic signed [HPW-1:0]  h_prod, h_rnd_full;
    logic signed [ACCW-1:0] h_rnd, h_next;
    logic signed [SB:0]     l_diff;
    logic signed [LPW-1:0]  l_prod, l_rnd_full;
    logic signed [ACCW-1:0] l_rnd, l_next;
    logic signed [ACCW-1:0] fin_val, sat_val;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    // Negative delays clamp to zero; the integer part wraps into the ring.
    assign dly_neg  = i_delay_amount[DELAY_BITS-1];
    assign dly_int  = dly_neg ? '0 : AW'(i_delay_amount[FRAC_BITS +: INT_BITS]);
    assign dly_frac = dly_neg ? '0 : i_delay_amount[FRAC_BITS-1:0];

    // State register and control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_wp        <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (in_accept && i_action == ACT_WRITE) begin
                r_wp <= r_wp + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next state, memory addressing and handshake.
    always_comb begin
        n_state    = r_state;
        mem_we     = 1'b0;
        mem_waddr  = r_wp;
        mem_raddr  = r_base;
        o_in_stall = 1'b1;
        out_load   = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_WRITE) begin
                        mem_we = 1'b1;
                    end else if (i_action inside {ACT_READ_LIN, ACT_READ_HERM}) begin
                        n_state = ST_RD0;
                    end
                end
            end
            ST_RD0: begin
                mem_raddr = r_base - AW'(1);
                n_state   = ST_RD1;
            end
            ST_RD1: begin
                mem_raddr = r_base;
                n_state   = r_herm ? ST_RD2 : ST_LIN;
            end
            ST_RD2: begin
                mem_raddr = r_base - AW'(2);
                n_state   = ST_RD3;
            end
            ST_RD3: begin
                mem_raddr = r_base + AW'(1);
                n_state   = ST_COEF;
            end
            ST_COEF: begin
                n_state = ST_HORNER;
            end
            ST_HORNER: begin
                if (r_step == 2'd2) begin
                    n_state = ST_DONE;
                end
            end
            ST_LIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sample memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_left[mem_waddr]  <= (r_state == ST_CLEAR) ? '0 : i_left_in;
            r_mem_right[mem_waddr] <= (r_state == ST_CLEAR) ? '0 : i_right_in;
        end
        r_rd_left  <= r_mem_left[mem_raddr];
        r_rd_right <= r_mem_right[mem_raddr];
    end

    assign rdata = r_chan ? r_rd_right : r_rd_left;

    // Coefficients, doubled so that they stay integer. The newest fetch is y3.
    assign y0_e = {{EXT{r_y0[SB-1]}}, r_y0};
    assign y1_e = {{EXT{r_y1[SB-1]}}, r_y1};
    assign y2_e = {{EXT{r_y2[SB-1]}}, r_y2};
    assign y3_e = {{EXT{rdata[SB-1]}}, rdata};
    assign d12  = y1_e - y2_e;
    assign k3   = y3_e - y0_e + d12 + (d12 <<< 1);
    assign k2   = (y0_e <<< 1) - (y1_e <<< 2) - y1_e + (y2_e <<< 2) - y3_e;
    assign k1   = y2_e - y0_e;
    assign k0   = y1_e <<< 1;

    // One Horner step: acc = round(acc * t) + k.
    assign t_val = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, r_frac};
    always_comb begin
        case (r_step)
            2'd0:    k_sel = r_k2;
            2'd1:    k_sel = r_k1;
            default: k_sel = r_k0;
        endcase
    end
    assign h_prod     = r_acc * $signed({1'b0, t_val});
    assign h_rnd_full = (h_prod + H_HALF) >>> FRAC_BITS;
    assign h_rnd      = h_rnd_full[ACCW-1:0];
    assign h_next     = h_rnd + k_sel;

    // Linear blend from y2 toward the older neighbour y1; y2 arrives on the read port.
    assign l_diff     = {r_y1[SB-1], r_y1} - {rdata[SB-1], rdata};
    assign l_prod     = l_diff * $signed({1'b0, r_frac});
    assign l_rnd_full = (l_prod + L_HALF) >>> FRAC_BITS;
    assign l_rnd      = l_rnd_full[ACCW-1:0];
    assign l_next     = {{EXT{rdata[SB-1]}}, rdata} + l_rnd;

    // Hermite results are halved back to sample scale, then both modes saturate.
    assign fin_val = r_herm ? ((r_acc + ACC_ONE) >>> 1) : r_acc;
    always_comb begin
        if (fin_val > SAT_MAX) begin
            sat_val = SAT_MAX;
        end else if (fin_val < SAT_MIN) begin
            sat_val = SAT_MIN;
        end else begin
            sat_val = fin_val;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_base <= r_wp - AW'(1) - dly_int;
            r_frac <= dly_frac;
            r_chan <= i_channel_sel;
            r_herm <= (i_action == ACT_READ_HERM);
        end
        case (r_state)
            ST_RD1: begin
                r_y1 <= rdata;
            end
            ST_RD2: begin
                r_y2 <= rdata;
            end
            ST_RD3: begin
                r_y0 <= rdata;
            end
            ST_COEF: begin
                r_acc  <= k3;
                r_k2   <= k2;
                r_k1   <= k1;
                r_k0   <= k0;
                r_step <= 2'd0;
            end
            ST_HORNER: begin
                r_acc  <= h_next;
                r_step <= r_step + 2'd1;
            end
            ST_LIN: begin
                r_acc <= l_next;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            r_out_data <= sat_val[SB-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_sample = r_out_data;

endmodule
